/* sv/rgbed_pkg.sv */
`timescale 1ns / 1ps

package rgbed_pkg;

    // Transaction opcodes on the input channel
    typedef enum logic [1:0] {
        OP_PIXEL = 2'd0,
        OP_MAP   = 2'd1,
        OP_PAL   = 2'd2
    } t_op;

    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
    } t_rgb;

    // Signed 9-bit quantization errors, one per channel
    typedef struct packed {
        logic [8:0] r;
        logic [8:0] g;
        logic [8:0] b;
    } t_err;

    // 16*v + 7*left + upleft + 5*up + 3*upright, floor /16, clamp to 0..255.
    // Horizontal-only mode drops the vertical terms and takes the full left error.
    function automatic logic [7:0] mix_chan(
        input logic [7:0] v,
        input logic       hmode,
        input logic [8:0] l,
        input logic [8:0] ul,
        input logic [8:0] up,
        input logic [8:0] ur
    );
        logic signed [14:0] sv;
        logic signed [14:0] sl;
        logic signed [14:0] sul;
        logic signed [14:0] sup;
        logic signed [14:0] sur;
        logic signed [14:0] s;
        logic signed [14:0] q;
        sv  = $signed({7'b0, v});
        sl  = $signed({{6{l[8]}}, l});
        sul = $signed({{6{ul[8]}}, ul});
        sup = $signed({{6{up[8]}}, up});
        sur = $signed({{6{ur[8]}}, ur});
        if (hmode) begin
            s = (sv + sl) <<< 4;
        end else begin
            s = (sv <<< 4) + 15'sd7 * sl + sul + 15'sd5 * sup + 15'sd3 * sur;
        end
        q = s >>> 4;
        if (q[14]) begin
            mix_chan = 8'd0;
        end else if (q > 15'sd255) begin
            mix_chan = 8'hff;
        end else begin
            mix_chan = q[7:0];
        end
    endfunction

endpackage

/* sv/rgbed_ram.sv */
`timescale 1ns / 1ps

module rgbed_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

/* sv/rgbed_mix.sv */
`timescale 1ns / 1ps

module rgbed_mix (
    input  rgbed_pkg::t_rgb i_pix,
    input  logic            i_hmode,
    input  rgbed_pkg::t_err i_left,
    input  rgbed_pkg::t_err i_ul,
    input  rgbed_pkg::t_err i_up,
    input  rgbed_pkg::t_err i_ur,
    output rgbed_pkg::t_rgb o_q,
    output logic [14:0]     o_map_addr
);

    always_comb begin
        o_q.r = rgbed_pkg::mix_chan(i_pix.r, i_hmode, i_left.r, i_ul.r, i_up.r, i_ur.r);
        o_q.g = rgbed_pkg::mix_chan(i_pix.g, i_hmode, i_left.g, i_ul.g, i_up.g, i_ur.g);
        o_q.b = rgbed_pkg::mix_chan(i_pix.b, i_hmode, i_left.b, i_ul.b, i_up.b, i_ur.b);
    end

    // 5-5-5 inverse map address from the clamped channels
    assign o_map_addr = {o_q.r[7:3], o_q.g[7:3], o_q.b[7:3]};

endmodule

/* sv/rgb_error_diffusion_palette_dither.sv */
`timescale 1ns / 1ps

// RGB to 8-bit palette index with Floyd-Steinberg error diffusion.
// Input channel (i_in_valid / o_in_stall) carries pixels (op 0) and table loads:
// op 1 writes one inverse-map entry, op 2 one palette colour. Load the tables
// before sending pixels. Output channel (o_out_valid / i_out_stall) gives one
// transaction per pixel: palette index plus a flag on the last pixel of a row.
// i_cfg_we / i_cfg_wdata set the row width; write it only while idle.
// A pixel passes the states IDLE, MAP, PAL and DONE before its result is
// registered; the first pixel of a row, or one after a resync to another
// column, also passes FILL1 and FILL2, as three line store slots are fetched
// instead of one. The core takes no new pixel before the last one is through
// the dependent chain of error-line read, inverse-map read and palette read
// that feeds the next pixel's left error. Loads are written as the idle core takes them.
// Reset: a clearing pass zeroes all MAX_WIDTH + 3 slots of the error line store
// (2051 at the default), with o_in_stall high; config writes are still taken.
// Receiver stall: the result register holds, the core waits at its last step,
// and a one-deep input buffer still takes one more transaction.
module rgb_error_diffusion_palette_dither #(
    parameter int MAX_WIDTH = 2048
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [11:0] i_cfg_wdata,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_op,
    input  logic [7:0]  i_red,
    input  logic [7:0]  i_green,
    input  logic [7:0]  i_blue,
    input  logic [14:0] i_table_address,
    input  logic [7:0]  i_table_value,
    input  logic        i_resync,
    input  logic [10:0] i_column,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_colour_index,
    output logic        o_row_done
);

    localparam int LINE_SLOTS = MAX_WIDTH + 3;
    localparam int XW = $clog2(MAX_WIDTH);
    localparam int LW = $clog2(LINE_SLOTS);
    localparam int WW = (XW + 1 > 12) ? XW + 1 : 12;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_FILL1,
        S_FILL2,
        S_MAP,
        S_PAL,
        S_DONE
    } t_state;

    t_state r_state;
    logic [LW-1:0] r_clr_addr;
    logic [11:0]   r_width;

    // input buffer
    logic            r_in_valid;
    logic [1:0]      r_in_op;
    rgbed_pkg::t_rgb r_in_pix;
    logic [14:0]     r_in_taddr;
    logic [7:0]      r_in_tval;
    logic            r_in_resync;
    logic [10:0]     r_in_column;

    // core state
    rgbed_pkg::t_err r_left;
    logic [XW-1:0]   r_col;
    logic            r_hmode;
    logic            r_win_ok;
    logic [XW-1:0]   r_win_next;
    rgbed_pkg::t_err r_ul;
    rgbed_pkg::t_err r_up;
    rgbed_pkg::t_err r_ur;
    rgbed_pkg::t_rgb r_pix;
    logic [XW-1:0]   r_x;
    logic            r_last;
    rgbed_pkg::t_rgb r_q;

    logic            r_out_valid;
    logic [7:0]      r_out_index;
    logic            r_out_row_done;

    // memories
    logic            line_wr_en;
    logic [LW-1:0]   line_wr_addr;
    rgbed_pkg::t_err line_wr_data;
    logic            line_rd_en;
    logic [LW-1:0]   line_rd_addr;
    rgbed_pkg::t_err line_rd_data;
    logic            map_wr_en;
    logic            map_rd_en;
    logic [7:0]      map_rd_data;
    logic            pal_wr_en;
    logic            pal_rd_en;
    rgbed_pkg::t_rgb pal_rd_data;

    logic [WW-1:0]   w_ext;
    logic [WW-1:0]   w_eff;
    logic [WW-1:0]   w_m1;
    logic [WW-1:0]   col_ext;
    logic [WW-1:0]   x_full;
    logic [XW-1:0]   x_new;
    logic            last_new;
    logic            win_hit;
    logic            take;
    logic            is_pixel;
    logic            in_acc;
    logic            out_free;
    rgbed_pkg::t_rgb mix_q;
    logic [14:0]     mix_addr;
    rgbed_pkg::t_err new_err;

    assign take     = (r_state == S_IDLE) && r_in_valid;
    assign is_pixel = (r_in_op == rgbed_pkg::OP_PIXEL);
    assign o_in_stall = (r_state == S_CLEAR) || (r_in_valid && (r_state != S_IDLE));
    assign in_acc   = i_in_valid && !o_in_stall;
    assign out_free = !r_out_valid || !i_out_stall;

    // effective width and column of the pixel in the buffer
    always_comb begin
        w_ext = WW'(r_width);
        if (w_ext == '0) begin
            w_eff = WW'(1);
        end else if (w_ext > WW'(MAX_WIDTH)) begin
            w_eff = WW'(MAX_WIDTH);
        end else begin
            w_eff = w_ext;
        end
        w_m1     = w_eff - WW'(1);
        col_ext  = r_in_resync ? WW'(r_in_column) : WW'(r_col);
        x_full   = (col_ext > w_m1) ? w_m1 : col_ext;
        x_new    = x_full[XW-1:0];
        last_new = (x_full == w_m1);
        // slots x and x+1 are still in the window from the previous pixel
        win_hit  = r_win_ok && (x_new == r_win_next);
    end

    // error line store port control
    always_comb begin
        line_wr_en   = 1'b0;
        line_wr_addr = LW'(r_x);
        line_wr_data = r_left;
        line_rd_en   = 1'b0;
        line_rd_addr = LW'(r_x);
        unique case (r_state)
            S_CLEAR: begin
                line_wr_en   = 1'b1;
                line_wr_addr = r_clr_addr;
                line_wr_data = '0;
            end
            S_IDLE: begin
                if (r_in_valid && is_pixel) begin
                    line_rd_en = 1'b1;
                    if (win_hit) begin
                        line_rd_addr = LW'(x_new) + LW'(2);
                        line_wr_en   = 1'b1;
                        line_wr_addr = LW'(x_new);
                        line_wr_data = r_in_resync ? '0 : r_left;
                    end else begin
                        line_rd_addr = LW'(x_new);
                    end
                end
            end
            S_FILL1: begin
                line_rd_en   = 1'b1;
                line_rd_addr = LW'(r_x) + LW'(1);
            end
            S_FILL2: begin
                line_rd_en   = 1'b1;
                line_rd_addr = LW'(r_x) + LW'(2);
                line_wr_en   = 1'b1;
            end
            default: ;
        endcase
    end

    assign map_wr_en = take && (r_in_op == rgbed_pkg::OP_MAP);
    assign map_rd_en = (r_state == S_MAP);
    assign pal_wr_en = take && (r_in_op == rgbed_pkg::OP_PAL) && (r_in_taddr[14:8] == '0);
    assign pal_rd_en = (r_state == S_PAL);

    always_comb begin
        new_err.r = {1'b0, r_q.r} - {1'b0, pal_rd_data.r};
        new_err.g = {1'b0, r_q.g} - {1'b0, pal_rd_data.g};
        new_err.b = {1'b0, r_q.b} - {1'b0, pal_rd_data.b};
    end

    rgbed_ram #(
        .WIDTH ($bits(rgbed_pkg::t_err)),
        .DEPTH (LINE_SLOTS)
    ) u_line_ram (
        .i_clk     (i_clk),
        .i_wr_en   (line_wr_en),
        .i_wr_addr (line_wr_addr),
        .i_wr_data (line_wr_data),
        .i_rd_en   (line_rd_en),
        .i_rd_addr (line_rd_addr),
        .o_rd_data (line_rd_data)
    );

    rgbed_ram #(
        .WIDTH (8),
        .DEPTH (32768)
    ) u_map_ram (
        .i_clk     (i_clk),
        .i_wr_en   (map_wr_en),
        .i_wr_addr (r_in_taddr),
        .i_wr_data (r_in_tval),
        .i_rd_en   (map_rd_en),
        .i_rd_addr (mix_addr),
        .o_rd_data (map_rd_data)
    );

    rgbed_ram #(
        .WIDTH ($bits(rgbed_pkg::t_rgb)),
        .DEPTH (256)
    ) u_pal_ram (
        .i_clk     (i_clk),
        .i_wr_en   (pal_wr_en),
        .i_wr_addr (r_in_taddr[7:0]),
        .i_wr_data (r_in_pix),
        .i_rd_en   (pal_rd_en),
        .i_rd_addr (map_rd_data),
        .o_rd_data (pal_rd_data)
    );

    rgbed_mix u_mix (
        .i_pix      (r_pix),
        .i_hmode    (r_hmode),
        .i_left     (r_left),
        .i_ul       (r_ul),
        .i_up       (r_up),
        .i_ur       (line_rd_data),
        .o_q        (mix_q),
        .o_map_addr (mix_addr)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_width     <= 12'd640;
            r_in_valid  <= 1'b0;
            r_left      <= '0;
            r_col       <= '0;
            r_hmode     <= 1'b0;
            r_win_ok    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_width <= i_cfg_wdata;
            end

            if (in_acc) begin
                r_in_valid  <= 1'b1;
                r_in_op     <= i_op;
                r_in_pix    <= '{r: i_red, g: i_green, b: i_blue};
                r_in_taddr  <= i_table_address;
                r_in_tval   <= i_table_value;
                r_in_resync <= i_resync;
                r_in_column <= i_column;
            end else if (take) begin
                r_in_valid <= 1'b0;
            end

            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_CLEAR: begin
                    r_clr_addr <= r_clr_addr + LW'(1);
                    if (r_clr_addr == LW'(LINE_SLOTS - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (r_in_valid && is_pixel) begin
                        r_pix  <= r_in_pix;
                        r_x    <= x_new;
                        r_last <= last_new;
                        if (r_in_resync) begin
                            r_hmode <= 1'b1;
                            r_left  <= '0;
                        end
                        if (win_hit) begin
                            r_ul    <= r_up;
                            r_up    <= r_ur;
                            r_state <= S_MAP;
                        end else begin
                            r_state <= S_FILL1;
                        end
                    end
                end
                S_FILL1: begin
                    r_ul    <= line_rd_data;
                    r_state <= S_FILL2;
                end
                S_FILL2: begin
                    r_up    <= line_rd_data;
                    r_state <= S_MAP;
                end
                S_MAP: begin
                    r_q     <= mix_q;
                    r_ur    <= line_rd_data;
                    r_state <= S_PAL;
                end
                S_PAL: begin
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (out_free) begin
                        r_out_valid    <= 1'b1;
                        r_out_index    <= map_rd_data;
                        r_out_row_done <= r_last;
                        r_win_ok       <= !r_last;
                        r_win_next     <= r_x + XW'(1);
                        if (r_last) begin
                            r_left  <= '0;
                            r_col   <= '0;
                            r_hmode <= 1'b0;
                        end else begin
                            r_left <= new_err;
                            r_col  <= r_x + XW'(1);
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_colour_index = r_out_index;
    assign o_row_done     = r_out_row_done;

`ifndef SYNTH
    a_clear_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !r_out_valid)
        else $error("result present during line store clearing");

    a_row_end_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && out_free && r_last) |=>
        (!r_hmode && r_left == '0 && r_col == '0 && !r_win_ok))
        else $error("row end did not reset diffusion state");

    a_buffer_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_state != S_IDLE) |=> r_in_valid)
        else $error("buffered transaction dropped while core busy");
`endif

endmodule

/* sim/tb_rgb_error_diffusion_palette_dither.sv */
`timescale 1ns / 1ps

module tb_rgb_error_diffusion_palette_dither;
    import rgbed_pkg::*;

    localparam int LINE_MAX        = 2048;
    localparam int LINE_SLOTS      = LINE_MAX + 3;
    localparam int MAP_DEPTH       = 32768;
    localparam int PAL_DEPTH       = 256;
    localparam logic [1:0] OP_RESERVED = 2'd3;
    localparam int GAP_MAX         = 17;
    localparam int IDLE_LIMIT      = 20000;
    localparam int SETTLE_CYCLES   = 8;
    localparam int ITEMS_PER_PHASE = 75;

    typedef struct packed {
        logic [1:0]  op;
        t_rgb        rgb;
        logic [14:0] addr;
        logic [7:0]  tval;
        logic        resync;
        logic [10:0] col;
    } t_xact;

    typedef struct packed {
        logic [7:0] idx;
        logic       done;
    } t_pix;

    typedef struct {
        t_xact tr;
        bit    typed;
        t_pix  want;
    } t_dir_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [11:0] i_cfg_wdata;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [1:0]  i_op;
    logic [7:0]  i_red;
    logic [7:0]  i_green;
    logic [7:0]  i_blue;
    logic [14:0] i_table_address;
    logic [7:0]  i_table_value;
    logic        i_resync;
    logic [10:0] i_column;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [7:0]  o_colour_index;
    logic        o_row_done;

    // dither state mirror
    logic [11:0]       row_width;
    logic [10:0]       next_col;
    logic              h_only;
    logic signed [8:0] left_err [3];
    logic signed [8:0] line_err [LINE_SLOTS][3];
    logic [7:0]        inv_map [MAP_DEPTH];
    t_rgb              pal_rgb [PAL_DEPTH];

    t_pix     pending_pix [$];
    t_dir_row dir_rows [$];
    t_rgb     drift;
    bit       send_burst;
    int       fail_count;
    int       idle_cycles;
    logic [11:0] phase_widths [8] = '{12'd3, 12'd0, 12'd1, 12'd4095,
                                      12'd2048, 12'd17, 12'd5, 12'd640};

    rgb_error_diffusion_palette_dither #(
        .MAX_WIDTH(LINE_MAX)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_op            (i_op),
        .i_red           (i_red),
        .i_green         (i_green),
        .i_blue          (i_blue),
        .i_table_address (i_table_address),
        .i_table_value   (i_table_value),
        .i_resync        (i_resync),
        .i_column        (i_column),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_colour_index  (o_colour_index),
        .o_row_done      (o_row_done)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Applies one transaction to the mirrored state; returns 1 when a pixel result is due.
    function automatic bit dither_step(input t_xact tr, output t_pix res);
        int         w;
        int         x;
        int         s;
        int         q;
        int         pal_lvl [3];
        logic [7:0] lvl [3];
        logic [14:0] maddr;
        logic [7:0] idx;
        t_rgb       pc;
        res = '0;
        dither_step = 1'b0;
        case (tr.op)
            OP_MAP: inv_map[tr.addr] = tr.tval;
            OP_PAL: if (tr.addr < PAL_DEPTH) pal_rgb[tr.addr[7:0]] = tr.rgb;
            OP_PIXEL: begin
                if (tr.resync) begin
                    next_col = tr.col;
                    h_only = 1'b1;
                    for (int c = 0; c < 3; c++) left_err[c] = '0;
                end
                w = int'(row_width);
                if (w == 0) w = 1;
                if (w > LINE_MAX) w = LINE_MAX;
                x = int'(next_col);
                if (x >= w) x = w - 1;
                lvl[0] = tr.rgb.r;
                lvl[1] = tr.rgb.g;
                lvl[2] = tr.rgb.b;
                for (int c = 0; c < 3; c++) begin
                    if (h_only) begin
                        s = 16 * (int'(lvl[c]) + left_err[c]);
                    end else begin
                        s = 16 * int'(lvl[c]) + 7 * left_err[c] + line_err[x][c]
                            + 5 * line_err[x + 1][c] + 3 * line_err[x + 2][c];
                    end
                    q = s >>> 4;
                    if (q > 255) q = 255;
                    if (q < 0) q = 0;
                    lvl[c] = q[7:0];
                    line_err[x][c] = left_err[c];
                end
                maddr = {lvl[0][7:3], lvl[1][7:3], lvl[2][7:3]};
                idx = inv_map[maddr];
                pc = pal_rgb[idx];
                pal_lvl[0] = int'(pc.r);
                pal_lvl[1] = int'(pc.g);
                pal_lvl[2] = int'(pc.b);
                for (int c = 0; c < 3; c++) left_err[c] = 9'(int'(lvl[c]) - pal_lvl[c]);
                res.idx = idx;
                if (x + 1 >= w) begin
                    res.done = 1'b1;
                    next_col = '0;
                    h_only = 1'b0;
                    for (int c = 0; c < 3; c++) left_err[c] = '0;
                end else begin
                    res.done = 1'b0;
                    next_col = 11'(x + 1);
                end
                dither_step = 1'b1;
            end
            default: ;
        endcase
    endfunction

    function automatic logic [7:0] pick_level(input logic [7:0] near);
        case ($urandom_range(0, 4))
            0: return $urandom_range(0, 1) ? 8'hff : 8'h00;
            1, 2: return 8'($urandom_range(0, 255));
            default: return near + 8'($urandom_range(0, 15)) - 8'd8;
        endcase
    endfunction

    function automatic void add_row(input logic [1:0] op, input logic [7:0] r, input logic [7:0] g,
                                    input logic [7:0] b, input logic [14:0] addr,
                                    input logic [7:0] tv, input logic rs,
                                    input logic [10:0] col, input bit typed,
                                    input logic [7:0] idx, input logic done);
        t_dir_row row;
        row.tr.op = op;
        row.tr.rgb.r = r;
        row.tr.rgb.g = g;
        row.tr.rgb.b = b;
        row.tr.addr = addr;
        row.tr.tval = tv;
        row.tr.resync = rs;
        row.tr.col = col;
        row.typed = typed;
        row.want.idx = idx;
        row.want.done = done;
        dir_rows.push_back(row);
    endfunction

    task automatic push_xact(input t_xact tr, input bit typed, input t_pix want,
                             input bit no_gap);
        int   gap;
        t_pix got;
        if (!no_gap && $urandom_range(0, 31) == 0) send_burst = !send_burst;
        gap = (no_gap || send_burst) ? 0 : $urandom_range(0, GAP_MAX);
        if (gap > 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_op = tr.op;
        i_red = tr.rgb.r;
        i_green = tr.rgb.g;
        i_blue = tr.rgb.b;
        i_table_address = tr.addr;
        i_table_value = tr.tval;
        i_resync = tr.resync;
        i_column = tr.col;
        i_in_valid = 1'b1;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        if (dither_step(tr, got)) pending_pix.push_back(typed ? want : got);
        @(negedge i_clk);
    endtask

    // Stop sending and wait for all outstanding pixels; optionally let loads finish.
    task automatic settle(input bit extra);
        i_in_valid = 1'b0;
        @(negedge i_clk);
        while (pending_pix.size() != 0) @(negedge i_clk);
        if (extra) repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic run_phase(input logic [11:0] w);
        t_xact tr;
        t_pix  no_pix;
        int    counted;
        int    sel;
        int    eff;
        settle(1'b1);
        i_cfg_wdata = w;
        i_cfg_we = 1'b1;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        row_width = w;
        eff = (w == 0) ? 1 : ((w > LINE_MAX) ? LINE_MAX : int'(w));
        no_pix = '0;
        counted = 0;
        while (counted < ITEMS_PER_PHASE) begin
            tr.rgb.r = 8'($urandom_range(0, 255));
            tr.rgb.g = 8'($urandom_range(0, 255));
            tr.rgb.b = 8'($urandom_range(0, 255));
            tr.addr = 15'($urandom_range(0, MAP_DEPTH - 1));
            tr.tval = 8'($urandom_range(0, 255));
            tr.resync = 1'b0;
            tr.col = 11'($urandom_range(0, 2047));
            sel = $urandom_range(0, 99);
            if (sel < 8) begin
                tr.op = OP_MAP;
            end else if (sel < 14) begin
                tr.op = OP_PAL;
                if ($urandom_range(0, 3) != 0) tr.addr = 15'($urandom_range(0, PAL_DEPTH - 1));
            end else if (sel < 17) begin
                tr.op = OP_RESERVED;
            end else begin
                tr.op = OP_PIXEL;
                tr.rgb.r = pick_level(drift.r);
                tr.rgb.g = pick_level(drift.g);
                tr.rgb.b = pick_level(drift.b);
                drift = tr.rgb;
                tr.resync = ($urandom_range(0, 11) == 0);
                // land resyncs near the row end half the time
                if (tr.resync && $urandom_range(0, 1) == 1)
                    tr.col = 11'(eff - 1 - $urandom_range(0, (eff > 4) ? 3 : eff - 1));
            end
            if (!(tr.op == OP_RESERVED || (tr.op == OP_PAL && tr.addr >= PAL_DEPTH)))
                counted++;
            push_xact(tr, 1'b0, no_pix, 1'b0);
            if ($urandom_range(0, 63) == 0) settle(1'b0);
        end
    endtask

    initial begin : out_stall_gen
        int hold;
        bit recv_burst;
        i_out_stall = 1'b0;
        recv_burst = 1'b0;
        @(negedge i_clk);
        forever begin
            if ($urandom_range(0, 31) == 0) recv_burst = !recv_burst;
            hold = recv_burst ? 0 : $urandom_range(0, GAP_MAX);
            if (hold > 0) begin
                i_out_stall = 1'b1;
                repeat (hold) @(negedge i_clk);
            end
            i_out_stall = 1'b0;
            do @(posedge i_clk); while (o_out_valid !== 1'b1);
            @(negedge i_clk);
        end
    end

    always @(posedge i_clk) begin : check_results
        t_pix exp_pix;
        if (i_rst_n === 1'b1 && o_out_valid === 1'b1 && i_out_stall === 1'b0) begin
            if (pending_pix.size() == 0) begin
                fail_count++;
                $display("%0t: unexpected transaction: colour_index %0d row_done %0d",
                         $time, o_colour_index, o_row_done);
            end else begin
                exp_pix = pending_pix.pop_front();
                if (o_colour_index !== exp_pix.idx) begin
                    fail_count++;
                    $display("%0t: colour_index expected %0d actual %0d",
                             $time, exp_pix.idx, o_colour_index);
                end
                if (o_row_done !== exp_pix.done) begin
                    fail_count++;
                    $display("%0t: row_done expected %0d actual %0d",
                             $time, exp_pix.done, o_row_done);
                end
            end
        end
        if ((i_in_valid === 1'b1 && o_in_stall === 1'b0)
            || (o_out_valid === 1'b1 && i_out_stall === 1'b0)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no transaction for %0d cycles, %0d pixels outstanding",
                     $time, idle_cycles, pending_pix.size());
            $display("tb_rgb_error_diffusion_palette_dither: errors");
            $finish;
        end
    end

    initial begin : stimulus
        t_xact tr;
        t_pix  no_pix;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = '0;
        i_in_valid = 1'b0;
        i_op = OP_PIXEL;
        i_red = '0;
        i_green = '0;
        i_blue = '0;
        i_table_address = '0;
        i_table_value = '0;
        i_resync = 1'b0;
        i_column = '0;
        fail_count = 0;
        idle_cycles = 0;
        send_burst = 1'b0;
        drift = '{r: 8'd128, g: 8'd128, b: 8'd128};
        no_pix = '0;
        row_width = 12'd640;
        next_col = '0;
        h_only = 1'b0;
        for (int c = 0; c < 3; c++) left_err[c] = '0;
        for (int i = 0; i < LINE_SLOTS; i++)
            for (int c = 0; c < 3; c++) line_err[i][c] = '0;

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // 3-3-2 inverse map and matching palette, every entry written
        for (int a = 0; a < MAP_DEPTH; a++) begin
            tr.op = OP_MAP;
            tr.addr = 15'(a);
            tr.tval = {tr.addr[14:12], tr.addr[9:7], tr.addr[4:3]};
            tr.rgb = t_rgb'($urandom_range(0, 32'hffffff));
            tr.resync = 1'($urandom_range(0, 1));
            tr.col = 11'($urandom_range(0, 2047));
            push_xact(tr, 1'b0, no_pix, 1'b1);
        end
        for (int p = 0; p < PAL_DEPTH; p++) begin
            tr.op = OP_PAL;
            tr.addr = 15'(p);
            tr.rgb.r = {tr.addr[7:5], tr.addr[7:5], tr.addr[7:6]};
            tr.rgb.g = {tr.addr[4:2], tr.addr[4:2], tr.addr[4:3]};
            tr.rgb.b = {4{tr.addr[1:0]}};
            tr.tval = 8'($urandom_range(0, 255));
            push_xact(tr, 1'b0, no_pix, 1'b1);
        end

        // op, r, g, b, addr, value, resync, column, typed, index, row_done
        add_row(OP_PIXEL, 8'd0, 8'd0, 8'd0, 15'd0, 8'd0, 1'b0, 11'd0, 1, 8'h00, 1'b0);
        add_row(OP_PIXEL, 8'd255, 8'd255, 8'd255, 15'h7fff, 8'hff, 1'b0, 11'h7ff,
                1, 8'hff, 1'b0);
        // resync past the row end saturates to the last column
        add_row(OP_PIXEL, 8'd0, 8'd0, 8'd255, 15'd0, 8'd0, 1'b1, 11'd2047, 1, 8'h03, 1'b1);
        add_row(OP_PIXEL, 8'd100, 8'd150, 8'd37, 15'd0, 8'd0, 1'b0, 11'd0, 0, 8'h00, 1'b0);
        add_row(OP_PIXEL, 8'd101, 8'd149, 8'd40, 15'd0, 8'd0, 1'b0, 11'd0, 0, 8'h00, 1'b0);
        add_row(OP_PIXEL, 8'd7, 8'd250, 8'd128, 15'd0, 8'd0, 1'b0, 11'd0, 0, 8'h00, 1'b0);
        // palette index above 255 is dropped
        add_row(OP_PAL, 8'd1, 8'd2, 8'd3, 15'd300, 8'd0, 1'b0, 11'd0, 0, 8'h00, 1'b0);
        add_row(OP_PAL, 8'd9, 8'd9, 8'd9, 15'h7fff, 8'd0, 1'b0, 11'd0, 0, 8'h00, 1'b0);
        add_row(OP_PAL, 8'd200, 8'd10, 8'd90, 15'd5, 8'd0, 1'b0, 11'd0, 0, 8'h00, 1'b0);
        add_row(OP_MAP, 8'd0, 8'd0, 8'd0, 15'h7fff, 8'd5, 1'b0, 11'd0, 0, 8'h00, 1'b0);
        add_row(OP_RESERVED, 8'hff, 8'hff, 8'hff, 15'h7fff, 8'hff, 1'b1, 11'h7ff,
                0, 8'h00, 1'b0);
        add_row(OP_PIXEL, 8'd255, 8'd255, 8'd255, 15'd0, 8'd0, 1'b0, 11'd0, 0, 8'h00, 1'b0);
        add_row(OP_PIXEL, 8'd0, 8'd0, 8'd0, 15'd0, 8'd0, 1'b0, 11'd0, 0, 8'h00, 1'b0);
        add_row(OP_PIXEL, 8'd128, 8'd128, 8'd128, 15'd0, 8'd0, 1'b1, 11'd5, 0, 8'h00, 1'b0);
        add_row(OP_PIXEL, 8'd128, 8'd128, 8'd128, 15'd0, 8'd0, 1'b0, 11'd0, 0, 8'h00, 1'b0);
        add_row(OP_PIXEL, 8'd60, 8'd200, 8'd30, 15'd0, 8'd0, 1'b1, 11'd638, 0, 8'h00, 1'b0);
        add_row(OP_PIXEL, 8'd60, 8'd200, 8'd30, 15'd0, 8'd0, 1'b0, 11'd0, 0, 8'h00, 1'b0);
        add_row(OP_PIXEL, 8'd60, 8'd200, 8'd30, 15'd0, 8'd0, 1'b0, 11'd0, 0, 8'h00, 1'b0);
        add_row(OP_MAP, 8'd0, 8'd0, 8'd0, 15'd0, 8'd0, 1'b0, 11'd0, 0, 8'h00, 1'b0);
        add_row(OP_PIXEL, 8'd255, 8'd0, 8'd255, 15'd0, 8'd0, 1'b0, 11'd0, 0, 8'h00, 1'b0);
        add_row(OP_PIXEL, 8'd0, 8'd255, 8'd0, 15'd0, 8'd0, 1'b0, 11'd0, 0, 8'h00, 1'b0);
        foreach (dir_rows[i]) push_xact(dir_rows[i].tr, dir_rows[i].typed, dir_rows[i].want, 1'b0);

        for (int p = 0; p < 8; p++) begin
            if (p == 6) begin
                run_phase(12'($urandom_range(2, 64)));
            end else begin
                run_phase(phase_widths[p]);
            end
        end

        settle(1'b0);
        repeat (10) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("tb_rgb_error_diffusion_palette_dither: clean");
        end else begin
            $display("tb_rgb_error_diffusion_palette_dither: errors");
        end
        $finish;
    end

endmodule
